@@ design/qmus_pkg.sv @@
// ----------------------------------------------------------------------------
// qmus_pkg
// Shared types and codes of the queued message UART serializer.
// ----------------------------------------------------------------------------
package qmus_pkg;

  localparam logic [1:0] FUNC_ENQ   = 2'd0;
  localparam logic [1:0] FUNC_TICK  = 2'd1;
  localparam logic [1:0] FUNC_CLEAR = 2'd2;

  localparam logic [1:0] STATUS_IDLE    = 2'd0;
  localparam logic [1:0] STATUS_BIT     = 2'd1;
  localparam logic [1:0] STATUS_MSG_END = 2'd2;

  localparam logic [3:0] BIT_START = 4'd0;
  localparam logic [3:0] BIT_STOP  = 4'd9;

  localparam int unsigned EntryWidth = 9;

  typedef enum logic {
    ST_IDLE,
    ST_LOAD
  } state_e;

  typedef struct packed {
    logic push;
    logic pop;
    logic clear;
  } store_ctrl_t;

  typedef struct packed {
    logic empty;
    logic full;
  } store_stat_t;

endpackage

@@ design/queued_message_uart_serializer_unit.sv @@
// ----------------------------------------------------------------------------
// queued_message_uart_serializer_unit
// 8N1 transmitter fed from a byte FIFO with end-of-message marks.
// ----------------------------------------------------------------------------
// Every item gives one result. A tick that sends a start bit moves the unit
// into its load state, in which it takes no new item and loads the head byte
// from the store's registered read port into the bit shift register. Data
// bits leave that shift register LSB first, one per tick. The store has
// no reset pass; its pointers and count clear at reset.
module queued_message_uart_serializer_unit
  import qmus_pkg::*;
#(
  parameter int unsigned FIFO_DEPTH = 256
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] func_i,
  input  logic [7:0] data_byte_i,
  input  logic       ends_message_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       line_level_o,
  output logic [1:0] tick_status_o,
  output logic       byte_accepted_o
);

  state_e                state_q, state_d;
  store_ctrl_t           ctrl;
  store_stat_t           stat;
  logic [EntryWidth-1:0] rdata;
  logic [3:0]            bit_pos_q, bit_pos_d;
  logic [7:0]            sh_q;
  logic                  end_q;
  logic                  shift_en;
  logic                  accept;
  logic                  out_valid_q;
  logic                  level_d, level_q;
  logic [1:0]            status_d, status_q;
  logic                  acc_d, acc_q;

  qmus_store #(
    .FIFO_DEPTH(FIFO_DEPTH)
  ) u_store (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (ctrl),
    .wdata_i({ends_message_i, data_byte_i}),
    .rdata_o(rdata),
    .stat_o (stat)
  );

  assign in_ready_o = (state_q == ST_IDLE) && (!out_valid_q || out_ready_i);
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    state_d   = state_q;
    bit_pos_d = bit_pos_q;
    ctrl      = '0;
    shift_en  = 1'b0;
    level_d   = 1'b1;
    status_d  = STATUS_IDLE;
    acc_d     = 1'b0;
    if (state_q == ST_LOAD) begin
      state_d = ST_IDLE;
    end
    if (accept) begin
      unique case (func_i)
        FUNC_ENQ: begin
          if (!stat.full) begin
            ctrl.push = 1'b1;
            acc_d     = 1'b1;
          end
        end
        FUNC_TICK: begin
          priority if (stat.empty) begin
            bit_pos_d = BIT_START;
          end else if (bit_pos_q == BIT_START) begin
            level_d   = 1'b0;
            status_d  = STATUS_BIT;
            bit_pos_d = bit_pos_q + 4'd1;
            state_d   = ST_LOAD;
          end else if (bit_pos_q >= BIT_STOP) begin
            level_d   = 1'b1;
            status_d  = end_q ? STATUS_MSG_END : STATUS_BIT;
            bit_pos_d = BIT_START;
            ctrl.pop  = 1'b1;
          end else begin
            level_d   = sh_q[0];
            status_d  = STATUS_BIT;
            bit_pos_d = bit_pos_q + 4'd1;
            shift_en  = 1'b1;
          end
        end
        FUNC_CLEAR: begin
          ctrl.clear = 1'b1;
          bit_pos_d  = BIT_START;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      bit_pos_q   <= BIT_START;
      out_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      bit_pos_q <= bit_pos_d;
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_LOAD) begin
      sh_q  <= rdata[7:0];
      end_q <= rdata[8];
    end else if (shift_en) begin
      sh_q <= {1'b0, sh_q[7:1]};
    end
    if (accept) begin
      level_q  <= level_d;
      status_q <= status_d;
      acc_q    <= acc_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign line_level_o    = level_q;
  assign tick_status_o   = status_q;
  assign byte_accepted_o = acc_q;

`ifndef NO_ASSERTIONS
  a_load_one_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_LOAD |=> state_q == ST_IDLE)
    else $error("load state held");
  a_bit_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bit_pos_q <= BIT_STOP)
    else $error("bit position out of frame");
  a_start_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && func_i == FUNC_TICK && !stat.empty && bit_pos_q == BIT_START
    |=> state_q == ST_LOAD && !line_level_o)
    else $error("start bit without head load");
  a_full_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && func_i == FUNC_ENQ && stat.full |=> out_valid_o && !byte_accepted_o)
    else $error("byte stored into full store");
`endif

endmodule

@@ design/qmus_store.sv @@
// ----------------------------------------------------------------------------
// qmus_store
// Byte FIFO: memory of character plus end mark, pointers and fill count.
// Read data is a register that takes the head entry on every clock.
// ----------------------------------------------------------------------------
module qmus_store
  import qmus_pkg::*;
#(
  parameter int unsigned FIFO_DEPTH = 256
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  store_ctrl_t           ctrl_i,
  input  logic [EntryWidth-1:0] wdata_i,
  output logic [EntryWidth-1:0] rdata_o,
  output store_stat_t           stat_o
);

  localparam int unsigned AW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int unsigned CW = $clog2(FIFO_DEPTH + 1);
  localparam logic [AW-1:0] LastIdx = AW'(FIFO_DEPTH - 1);
  localparam logic [CW-1:0] FullCnt = CW'(FIFO_DEPTH);

  logic [EntryWidth-1:0] mem_q [FIFO_DEPTH];
  logic [EntryWidth-1:0] rdata_q;
  logic [AW-1:0]         rd_ptr_q, rd_ptr_d;
  logic [AW-1:0]         wr_ptr_q, wr_ptr_d;
  logic [CW-1:0]         cnt_q, cnt_d;

  always_comb begin
    rd_ptr_d = rd_ptr_q;
    wr_ptr_d = wr_ptr_q;
    cnt_d    = cnt_q;
    if (ctrl_i.clear) begin
      rd_ptr_d = '0;
      wr_ptr_d = '0;
      cnt_d    = '0;
    end else if (ctrl_i.push) begin
      wr_ptr_d = (wr_ptr_q == LastIdx) ? '0 : wr_ptr_q + AW'(1);
      cnt_d    = cnt_q + CW'(1);
    end else if (ctrl_i.pop) begin
      rd_ptr_d = (rd_ptr_q == LastIdx) ? '0 : rd_ptr_q + AW'(1);
      cnt_d    = cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_ptr_q <= '0;
      wr_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      rd_ptr_q <= rd_ptr_d;
      wr_ptr_q <= wr_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.push && !ctrl_i.clear) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
    rdata_q <= mem_q[rd_ptr_q];
  end

  assign rdata_o      = rdata_q;
  assign stat_o.empty = (cnt_q == '0);
  assign stat_o.full  = (cnt_q == FullCnt);

`ifndef NO_ASSERTIONS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= FullCnt)
    else $error("fill count beyond depth");
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat_o.full && ctrl_i.push |-> ctrl_i.clear)
    else $error("push into full store");
  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat_o.empty && ctrl_i.pop |-> ctrl_i.clear)
    else $error("pop from empty store");
`endif

endmodule

@@ bench/qmus_line_checker.sv @@
// ----------------------------------------------------------------------------
// qmus_line_checker
// Watches both channels of the UART serializer and predicts the line result
// of every accepted item from its own copy of the byte queue and frame
// cursor. Compares each result field by field, in order.
// ----------------------------------------------------------------------------
module qmus_line_checker
  import qmus_pkg::*;
#(
  parameter int unsigned FIFO_DEPTH = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [1:0]  func_i,
  input  logic [7:0]  data_byte_i,
  input  logic        ends_message_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic        line_level_i,
  input  logic [1:0]  tick_status_i,
  input  logic        byte_accepted_i,
  output int unsigned error_count_o,
  output int unsigned pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic       line_level;
    logic [1:0] tick_status;
    logic       byte_accepted;
  } line_result_t;

  logic [EntryWidth-1:0] queue_mem [FIFO_DEPTH];
  int unsigned           rd_idx;
  int unsigned           wr_idx;
  int unsigned           fill_count;
  logic [3:0]            frame_pos;
  line_result_t          expected_line_q [$];
  int unsigned           mismatch_count;

  assign error_count_o = mismatch_count;

  task automatic report_mismatch(input string what);
    $display("[%0t] ERROR %s", $time, what);
    mismatch_count++;
  endtask

  task automatic advance_serializer(input logic [1:0] fn, input logic [7:0] data,
                                    input logic ends);
    line_result_t          res;
    logic [EntryWidth-1:0] head;
    res = '{line_level: 1'b1, tick_status: STATUS_IDLE, byte_accepted: 1'b0};
    case (fn)
      FUNC_ENQ: begin
        if (fill_count < FIFO_DEPTH) begin
          queue_mem[wr_idx] = {ends, data};
          wr_idx = (wr_idx + 1) % FIFO_DEPTH;
          fill_count++;
          res.byte_accepted = 1'b1;
        end
      end
      FUNC_TICK: begin
        if (fill_count == 0) begin
          frame_pos = BIT_START;
        end else begin
          head = queue_mem[rd_idx];
          if (frame_pos == BIT_START) res.line_level = 1'b0;
          else if (frame_pos < BIT_STOP) res.line_level = head[frame_pos - 1];
          else res.line_level = 1'b1;
          if (frame_pos == BIT_STOP) begin
            frame_pos = BIT_START;
            rd_idx = (rd_idx + 1) % FIFO_DEPTH;
            fill_count--;
            res.tick_status = head[EntryWidth-1] ? STATUS_MSG_END : STATUS_BIT;
          end else begin
            frame_pos = frame_pos + 4'd1;
            res.tick_status = STATUS_BIT;
          end
        end
      end
      FUNC_CLEAR: begin
        rd_idx = 0;
        wr_idx = 0;
        fill_count = 0;
        frame_pos = BIT_START;
      end
      default: ;
    endcase
    expected_line_q.push_back(res);
  endtask

  task automatic check_line_result();
    line_result_t want;
    if (expected_line_q.size() == 0) begin
      report_mismatch("result arrived with nothing expected");
      return;
    end
    want = expected_line_q.pop_front();
    if (line_level_i !== want.line_level)
      report_mismatch($sformatf("line_level got %0b want %0b", line_level_i,
                                want.line_level));
    if (tick_status_i !== want.tick_status)
      report_mismatch($sformatf("tick_status got %0d want %0d", tick_status_i,
                                want.tick_status));
    if (byte_accepted_i !== want.byte_accepted)
      report_mismatch($sformatf("byte_accepted got %0b want %0b", byte_accepted_i,
                                want.byte_accepted));
  endtask

  initial mismatch_count = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_idx = 0;
      wr_idx = 0;
      fill_count = 0;
      frame_pos = BIT_START;
      expected_line_q.delete();
    end else begin
      if (in_valid_i && in_ready_i) advance_serializer(func_i, data_byte_i, ends_message_i);
      if (out_valid_i && out_ready_i) check_line_result();
    end
    pending_o = expected_line_q.size();
  end

endmodule

@@ bench/queued_message_uart_serializer_unit_tb.sv @@
// ----------------------------------------------------------------------------
// queued_message_uart_serializer_unit_tb
// Drives enqueue, tick, clear and unused commands into the serializer under
// several idle and stall mixes, while a checker predicts every line result.
// ----------------------------------------------------------------------------
module queued_message_uart_serializer_unit_tb;
  import qmus_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DEPTH       = 256;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam logic [1:0]  FUNC_UNUSED = 2'd3;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [1:0]  func_i;
  logic [7:0]  data_byte_i;
  logic        ends_message_i;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic        line_level_o;
  logic [1:0]  tick_status_o;
  logic        byte_accepted_o;
  int unsigned error_count;
  int unsigned pending;
  int unsigned gap_pct;
  int unsigned stall_pct;
  int unsigned items_sent;
  int unsigned cycle_count;

  queued_message_uart_serializer_unit #(.FIFO_DEPTH(DEPTH)) u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .func_i         (func_i),
    .data_byte_i    (data_byte_i),
    .ends_message_i (ends_message_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .line_level_o   (line_level_o),
    .tick_status_o  (tick_status_o),
    .byte_accepted_o(byte_accepted_o)
  );

  qmus_line_checker #(.FIFO_DEPTH(DEPTH)) u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_i     (in_ready_o),
    .func_i         (func_i),
    .data_byte_i    (data_byte_i),
    .ends_message_i (ends_message_i),
    .out_valid_i    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .line_level_i   (line_level_o),
    .tick_status_i  (tick_status_o),
    .byte_accepted_i(byte_accepted_o),
    .error_count_o  (error_count),
    .pending_o      (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial cycle_count = 0;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  always @(posedge clk_i) out_ready_i <= ($urandom_range(99) >= stall_pct);

  task automatic send_item(input logic [1:0] fn, input logic [7:0] data, input logic ends);
    logic ready_seen;
    if ($urandom_range(99) < gap_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < gap_pct);
    end
    in_valid_i     <= 1'b1;
    func_i         <= fn;
    data_byte_i    <= data;
    ends_message_i <= ends;
    do begin
      @(negedge clk_i);
      ready_seen = in_ready_o;
      @(posedge clk_i);
    end while (!ready_seen);
    items_sent++;
  endtask

  task automatic send_ticks(input int unsigned n);
    repeat (n) send_item(FUNC_TICK, 8'($urandom), 1'($urandom));
  endtask

  task automatic run_traffic(input int unsigned n_items);
    int unsigned stop_at;
    int unsigned pick;
    int unsigned len;
    stop_at = items_sent + n_items;
    while (items_sent < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 78) begin
        len = $urandom_range(1, 4);
        for (int unsigned k = 0; k < len; k++)
          send_item(FUNC_ENQ, 8'($urandom), k == len - 1);
        send_ticks(len * 10 + $urandom_range(0, 6) - 3);
      end else if (pick < 88) begin
        repeat ($urandom_range(1, 3)) send_item(FUNC_ENQ, 8'($urandom), 1'($urandom));
        send_ticks($urandom_range(0, 14));
      end else if (pick < 93) begin
        send_item(FUNC_CLEAR, 8'($urandom), 1'($urandom));
      end else if (pick < 96) begin
        send_item(FUNC_UNUSED, 8'($urandom), 1'($urandom));
      end else begin
        send_ticks($urandom_range(1, 5));
      end
    end
  endtask

  initial begin
    rst_ni         <= 1'b0;
    in_valid_i     <= 1'b0;
    func_i         <= FUNC_TICK;
    data_byte_i    <= 8'h00;
    ends_message_i <= 1'b0;
    gap_pct    = 0;
    stall_pct  = 0;
    items_sent = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_item(FUNC_TICK, 8'hFF, 1'b1);
    send_item(FUNC_UNUSED, 8'hFF, 1'b1);
    send_item(FUNC_ENQ, 8'h00, 1'b0);
    send_item(FUNC_ENQ, 8'hFF, 1'b1);
    send_ticks(20);
    send_item(FUNC_ENQ, 8'h5A, 1'b1);
    send_ticks(3);
    send_item(FUNC_CLEAR, 8'h00, 1'b0);
    send_item(FUNC_TICK, 8'h00, 1'b0);

    run_traffic(230);

    send_item(FUNC_CLEAR, 8'h00, 1'b0);
    repeat (DEPTH + 2) send_item(FUNC_ENQ, 8'($urandom), 1'($urandom));
    send_ticks(25);
    repeat (3) send_item(FUNC_ENQ, 8'($urandom), 1'($urandom));
    send_ticks(15);
    send_item(FUNC_CLEAR, 8'h00, 1'b0);

    gap_pct = 69;
    run_traffic(230);
    gap_pct   = 0;
    stall_pct = 69;
    run_traffic(230);
    gap_pct   = 29;
    stall_pct = 29;
    run_traffic(230);

    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
    repeat (10) @(posedge clk_i);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

@@ sim.f @@
design/qmus_pkg.sv
design/qmus_store.sv
design/queued_message_uart_serializer_unit.sv
bench/qmus_line_checker.sv
bench/queued_message_uart_serializer_unit_tb.sv
